FILE: hdl/sfa_pkg.sv
package sfa_pkg;

  localparam int MaxFreeBlocksDef = 32;
  localparam int MaxSegmentsDef   = 4;
  localparam int HeaderBytesDef   = 24;
  localparam int AddrBitsDef      = 32;
  localparam int Grain            = 8;
  localparam int MinRest          = 16;

  typedef enum logic [2:0] {
    REQ_INIT   = 3'd0,
    REQ_ALLOC  = 3'd1,
    REQ_FREE   = 3'd2,
    REQ_EXPAND = 3'd3,
    REQ_PEAK   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INVALID    = 2'd1,
    ST_NO_SPACE   = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_MAXF_RD, S_MAXF_EV, S_MAXF_CHK, S_FIT_RD, S_FIT_EV,
    S_NEXT_SEG, S_MRG_RD, S_MRG_EV, S_MRG_CHK, S_CMP_RD, S_CMP_EV, S_CMP_END,
    S_SHR_RD, S_SHR_EV, S_FINISH
  } state_t;

  typedef struct packed {
    logic    load_req;
    logic    do_init;
    logic    do_peak;
    logic    alloc_start;
    logic    seg_next;
    logic    scan_rst;
    logic    rd_i;
    logic    maxf_ev;
    logic    fit_ev;
    logic    merge_start;
    logic    merge_ev;
    logic    merge_commit;
    logic    cmp_start;
    logic    cmp_rd;
    logic    cmp_ev;
    logic    cmp_end;
    logic    shr_rd;
    logic    shr_ev;
    logic    push0;
    logic    out_load;
    logic    set_st;
    status_t st;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic addr_zero;
    logic len_zero;
    logic len_ok;
    logic ready;
    logic seg_empty;
    logic seg_full;
    logic i_end;
    logic j_end;
    logic j_zero;
    logic last_seg;
    logic maxf_short;
    logic fit_hit;
    logic table_full;
    logic push;
  } sts_t;

endpackage

FILE: hdl/sfa_ctrl.sv
module sfa_ctrl import sfa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.st        = ST_OK;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        unique case (sts.req)
          REQ_INIT: begin
            if (!sts.addr_zero && sts.len_ok) begin
              cmd.do_init = 1'b1;
              cmd.set_st  = 1'b1;
              cmd.st      = ST_OK;
            end
          end
          REQ_ALLOC: begin
            if (!sts.len_zero) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_NO_SPACE;
              if (sts.ready && !sts.seg_empty) begin
                cmd.alloc_start = 1'b1;
                state_nxt       = S_MAXF_RD;
              end
            end
          end
          REQ_FREE: begin
            if (!sts.addr_zero) begin
              cmd.merge_start = 1'b1;
              state_nxt       = S_MRG_RD;
            end
          end
          REQ_EXPAND: begin
            if (!sts.addr_zero && sts.len_ok) begin
              if (sts.seg_full) begin
                cmd.set_st = 1'b1;
                cmd.st     = ST_NO_SPACE;
              end else begin
                cmd.merge_start = 1'b1;
                state_nxt       = S_MRG_RD;
              end
            end
          end
          REQ_PEAK: begin
            cmd.do_peak = 1'b1;
            cmd.set_st  = 1'b1;
            cmd.st      = ST_OK;
          end
          default: ;
        endcase
      end
      S_MAXF_RD: begin
        if (sts.i_end) begin
          state_nxt = S_MAXF_CHK;
        end else begin
          cmd.rd_i  = 1'b1;
          state_nxt = S_MAXF_EV;
        end
      end
      S_MAXF_EV: begin
        cmd.maxf_ev = 1'b1;
        state_nxt   = S_MAXF_RD;
      end
      S_MAXF_CHK: begin
        if (sts.maxf_short) begin
          state_nxt = S_NEXT_SEG;
        end else begin
          cmd.scan_rst = 1'b1;
          state_nxt    = S_FIT_RD;
        end
      end
      S_FIT_RD: begin
        if (sts.i_end) begin
          state_nxt = S_NEXT_SEG;
        end else begin
          cmd.rd_i  = 1'b1;
          state_nxt = S_FIT_EV;
        end
      end
      S_FIT_EV: begin
        cmd.fit_ev = 1'b1;
        if (sts.fit_hit) begin
          cmd.set_st    = 1'b1;
          cmd.st        = ST_OK;
          cmd.cmp_start = 1'b1;
          state_nxt     = S_CMP_RD;
        end else begin
          state_nxt = S_FIT_RD;
        end
      end
      S_NEXT_SEG: begin
        if (sts.last_seg) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.seg_next = 1'b1;
          state_nxt    = S_MAXF_RD;
        end
      end
      S_MRG_RD: begin
        if (sts.i_end) begin
          state_nxt = S_MRG_CHK;
        end else begin
          cmd.rd_i  = 1'b1;
          state_nxt = S_MRG_EV;
        end
      end
      S_MRG_EV: begin
        cmd.merge_ev = 1'b1;
        state_nxt    = S_MRG_RD;
      end
      S_MRG_CHK: begin
        cmd.set_st = 1'b1;
        if (sts.table_full) begin
          cmd.st    = ST_TABLE_FULL;
          state_nxt = S_FINISH;
        end else begin
          cmd.st           = ST_OK;
          cmd.merge_commit = 1'b1;
          cmd.cmp_start    = 1'b1;
          state_nxt        = S_CMP_RD;
        end
      end
      S_CMP_RD: begin
        if (sts.j_end) begin
          state_nxt = S_CMP_END;
        end else begin
          cmd.cmp_rd = 1'b1;
          state_nxt  = S_CMP_EV;
        end
      end
      S_CMP_EV: begin
        cmd.cmp_ev = 1'b1;
        state_nxt  = S_CMP_RD;
      end
      S_CMP_END: begin
        cmd.cmp_end = 1'b1;
        state_nxt   = sts.push ? S_SHR_RD : S_FINISH;
      end
      S_SHR_RD: begin
        if (sts.j_zero) begin
          cmd.push0 = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          cmd.shr_rd = 1'b1;
          state_nxt  = S_SHR_EV;
        end
      end
      S_SHR_EV: begin
        cmd.shr_ev = 1'b1;
        state_nxt  = S_SHR_RD;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: hdl/sfa_dp.sv
module sfa_dp import sfa_pkg::*; #(
  parameter int MAX_FREE_BLOCKS = MaxFreeBlocksDef,
  parameter int MAX_SEGMENTS    = MaxSegmentsDef,
  parameter int HEADER_BYTES    = HeaderBytesDef,
  parameter int ADDR_BITS       = AddrBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_addr,
  input  logic [31:0] in_length,
  output logic [1:0]  out_status,
  output logic [31:0] out_block_addr,
  output logic [31:0] out_capacity,
  output logic [15:0] out_live_count,
  output logic [15:0] out_peak_count,
  output logic [31:0] out_total_bytes
);

  localparam int IDX_W  = $clog2(MAX_FREE_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_FREE_BLOCKS + 1);
  localparam int SIDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SCNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int IW     = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1;
  localparam logic [31:0] HDR32     = 32'(HEADER_BYTES);
  localparam logic [31:0] MIN_SPLIT = 32'(HEADER_BYTES + MinRest);
  localparam logic [32:0] GRAIN_M1  = 33'(Grain - 1);

  function automatic logic [ADDR_BITS-1:0] end_of(input logic [ADDR_BITS-1:0] a,
                                                  input logic [31:0] s);
    end_of = a + ADDR_BITS'(HEADER_BYTES) + ADDR_BITS'(s);
  endfunction

  // Free table memory with a registered read port.
  logic [ADDR_BITS-1:0] fa_mem_r [MAX_FREE_BLOCKS];
  logic [31:0]          fs_mem_r [MAX_FREE_BLOCKS];
  logic [ADDR_BITS-1:0] rd_a_r;
  logic [31:0]          rd_s_r;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa, mem_ra;
  logic [ADDR_BITS-1:0] mem_wd_a;
  logic [31:0]          mem_wd_s;

  logic [ADDR_BITS-1:0] seg_base_r [MAX_SEGMENTS];
  logic [31:0]          seg_len_r  [MAX_SEGMENTS];

  req_t                 req_r;
  logic [ADDR_BITS-1:0] addr_r, ma_r;
  logic [31:0]          len_r, ms_r, maxf_r;
  logic [CNT_W-1:0]     n_r, i_r, j_r, w_r, kn_r;
  logic [SCNT_W-1:0]    seg_n_r, k_r;
  logic [MAX_FREE_BLOCKS-1:0] kept_r;
  logic                 push_r, ready_r;
  logic [15:0]          live_r, peak_r;
  logic [31:0]          pool_r;
  status_t              res_st_r;
  logic [31:0]          res_addr_r, res_cap_r;

  logic [32:0]          want;
  logic                 in_seg, hit;
  logic [ADDR_BITS-1:0] kbase;
  logic [31:0]          klen;
  logic [CNT_W-1:0]     jm1;
  logic [SCNT_W-1:0]    at;
  logic [31:0]          rest;
  logic [15:0]          live_inc;
  logic [ADDR_BITS-1:0] end_rd, end_cur;

  assign want    = ({1'b0, len_r} + GRAIN_M1) & ~GRAIN_M1;
  assign kbase   = seg_base_r[k_r[SIDX_W-1:0]];
  assign klen    = seg_len_r[k_r[SIDX_W-1:0]];
  assign in_seg  = (IW'(rd_a_r) >= IW'(kbase)) && (IW'(rd_a_r) < IW'(kbase) + IW'(klen));
  assign hit     = in_seg && ({1'b0, rd_s_r} >= want);
  assign jm1     = j_r - CNT_W'(1);
  assign rest    = rd_s_r - want[31:0];
  assign live_inc = (live_r == 16'hFFFF) ? live_r : live_r + 16'd1;
  assign end_rd  = end_of(rd_a_r, rd_s_r);
  assign end_cur = end_of(ma_r, ms_r);

  // Sorted insert point: equal lengths go after the ones already there.
  always_comb begin
    at = '0;
    for (int s = 0; s < MAX_SEGMENTS; s++) begin
      if ((SCNT_W'(s) < seg_n_r) && !(len_r < seg_len_r[s])) at = at + SCNT_W'(1);
    end
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd_a = rd_a_r;
    mem_wd_s = rd_s_r;
    if (cmd.do_init) begin
      mem_we   = 1'b1;
      mem_wd_a = addr_r;
      mem_wd_s = len_r - HDR32;
    end else if (cmd.cmp_ev && kept_r[j_r[IDX_W-1:0]]) begin
      mem_we = 1'b1;
      mem_wa = w_r[IDX_W-1:0];
    end else if (cmd.shr_ev) begin
      mem_we = 1'b1;
      mem_wa = j_r[IDX_W-1:0];
    end else if (cmd.push0) begin
      mem_we   = 1'b1;
      mem_wd_a = ma_r;
      mem_wd_s = ms_r;
    end
    if (cmd.cmp_rd)      mem_ra = j_r[IDX_W-1:0];
    else if (cmd.shr_rd) mem_ra = jm1[IDX_W-1:0];
    else                 mem_ra = i_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fa_mem_r[mem_wa] <= mem_wd_a;
      fs_mem_r[mem_wa] <= mem_wd_s;
    end
    rd_a_r <= fa_mem_r[mem_ra];
    rd_s_r <= fs_mem_r[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= '0;
      seg_n_r <= '0;
      live_r  <= '0;
      peak_r  <= '0;
      pool_r  <= '0;
      ready_r <= 1'b0;
    end else begin
      if (cmd.do_init) begin
        n_r     <= CNT_W'(1);
        seg_n_r <= SCNT_W'(1);
        live_r  <= '0;
        peak_r  <= '0;
        pool_r  <= len_r;
        ready_r <= 1'b1;
      end
      if (cmd.do_peak) peak_r <= live_r;
      if (cmd.fit_ev && hit) begin
        live_r <= live_inc;
        if (live_inc > peak_r) peak_r <= live_inc;
      end
      if (cmd.merge_commit) begin
        if (req_r == REQ_FREE && live_r != '0) live_r <= live_r - 16'd1;
        if (req_r == REQ_EXPAND) begin
          seg_n_r <= seg_n_r + SCNT_W'(1);
          pool_r  <= pool_r + len_r;
        end
      end
      if (cmd.cmp_end) n_r <= w_r;
      if (cmd.push0)   n_r <= n_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r      <= req_t'(in_req_type);
      addr_r     <= ADDR_BITS'(in_addr);
      len_r      <= in_length;
      res_st_r   <= ST_INVALID;
      res_addr_r <= '0;
      res_cap_r  <= '0;
    end
    if (cmd.set_st) res_st_r <= cmd.st;
    if (cmd.do_init) begin
      seg_base_r[0] <= addr_r;
      seg_len_r[0]  <= len_r;
    end
    if (cmd.merge_commit && req_r == REQ_EXPAND) begin
      for (int s = 0; s < MAX_SEGMENTS; s++) begin
        if (SCNT_W'(s) == at) begin
          seg_base_r[s] <= addr_r;
          seg_len_r[s]  <= len_r;
        end else if (s > 0 && SCNT_W'(s) > at && SCNT_W'(s) <= seg_n_r) begin
          seg_base_r[s] <= seg_base_r[s-1];
          seg_len_r[s]  <= seg_len_r[s-1];
        end
      end
    end
    if (cmd.alloc_start) begin
      k_r    <= '0;
      i_r    <= '0;
      maxf_r <= '0;
    end
    if (cmd.seg_next) begin
      k_r    <= k_r + SCNT_W'(1);
      i_r    <= '0;
      maxf_r <= '0;
    end
    if (cmd.scan_rst) i_r <= '0;
    if (cmd.maxf_ev) begin
      if (in_seg && rd_s_r > maxf_r) maxf_r <= rd_s_r;
      i_r <= i_r + CNT_W'(1);
    end
    if (cmd.fit_ev) begin
      if (hit) begin
        kept_r     <= ~({{(MAX_FREE_BLOCKS-1){1'b0}}, 1'b1} << i_r[IDX_W-1:0]);
        res_addr_r <= 32'(rd_a_r);
        if (rest >= MIN_SPLIT) begin
          push_r    <= 1'b1;
          ma_r      <= end_of(rd_a_r, want[31:0]);
          ms_r      <= rest - HDR32;
          res_cap_r <= want[31:0];
        end else begin
          push_r    <= 1'b0;
          res_cap_r <= rd_s_r;
        end
      end else begin
        i_r <= i_r + CNT_W'(1);
      end
    end
    if (cmd.merge_start) begin
      ma_r   <= addr_r;
      ms_r   <= (req_r == REQ_EXPAND) ? len_r - HDR32 : len_r;
      kept_r <= '0;
      kn_r   <= '0;
      i_r    <= '0;
      push_r <= 1'b1;
    end
    if (cmd.merge_ev) begin
      if (end_rd == ma_r) begin
        ms_r <= rd_s_r + HDR32 + ms_r;
        ma_r <= rd_a_r;
      end else if (end_cur == rd_a_r) begin
        ms_r <= ms_r + HDR32 + rd_s_r;
      end else begin
        kept_r[i_r[IDX_W-1:0]] <= 1'b1;
        kn_r <= kn_r + CNT_W'(1);
      end
      i_r <= i_r + CNT_W'(1);
    end
    if (cmd.cmp_start) begin
      j_r <= '0;
      w_r <= '0;
    end
    if (cmd.cmp_ev) begin
      if (kept_r[j_r[IDX_W-1:0]]) w_r <= w_r + CNT_W'(1);
      j_r <= j_r + CNT_W'(1);
    end
    if (cmd.cmp_end) j_r <= w_r;
    if (cmd.shr_ev)  j_r <= jm1;
    if (cmd.out_load) begin
      out_status      <= res_st_r;
      out_block_addr  <= res_addr_r;
      out_capacity    <= res_cap_r;
      out_live_count  <= live_r;
      out_peak_count  <= peak_r;
      out_total_bytes <= pool_r;
    end
  end

  always_comb begin
    sts            = '0;
    sts.req        = req_r;
    sts.addr_zero  = (addr_r == '0);
    sts.len_zero   = (len_r == '0);
    sts.len_ok     = (len_r >= MIN_SPLIT);
    sts.ready      = ready_r;
    sts.seg_empty  = (seg_n_r == '0);
    sts.seg_full   = (seg_n_r >= SCNT_W'(MAX_SEGMENTS));
    sts.i_end      = (i_r == n_r);
    sts.j_end      = (j_r == n_r);
    sts.j_zero     = (j_r == '0);
    sts.last_seg   = (k_r + SCNT_W'(1) >= seg_n_r);
    sts.maxf_short = (maxf_r < len_r);
    sts.fit_hit    = hit;
    sts.table_full = (kn_r >= CNT_W'(MAX_FREE_BLOCKS));
    sts.push       = push_r;
  end

endmodule

FILE: hdl/segmented_first_fit_allocator.sv
// First-fit pool allocator over up to MAX_SEGMENTS segments with a coalescing free
// table of MAX_FREE_BLOCKS entries. One request is handled at a time; in_stall is
// high from acceptance until the result is loaded into the output register. Init,
// peak reset and rejected requests go from decode straight to the finish state.
// Every pass over the free table reads and then evaluates each entry in turn because the
// table sits in a memory with one registered read port: alloc needs up to two passes per
// segment tried plus one compaction and, on a split, one shift pass; free and expand
// need a merge pass, a compaction pass and a shift pass. A stalled output register
// holds the last state until it drains. No clearing pass follows reset.
module segmented_first_fit_allocator import sfa_pkg::*; #(
  parameter int MAX_FREE_BLOCKS = MaxFreeBlocksDef,
  parameter int MAX_SEGMENTS    = MaxSegmentsDef,
  parameter int HEADER_BYTES    = HeaderBytesDef,
  parameter int ADDR_BITS       = AddrBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_addr,
  input  logic [31:0] in_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_block_addr,
  output logic [31:0] out_capacity,
  output logic [15:0] out_live_count,
  output logic [15:0] out_peak_count,
  output logic [31:0] out_total_bytes
);

  cmd_t cmd;
  sts_t sts;

  sfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfa_dp #(
    .MAX_FREE_BLOCKS (MAX_FREE_BLOCKS),
    .MAX_SEGMENTS    (MAX_SEGMENTS),
    .HEADER_BYTES    (HEADER_BYTES),
    .ADDR_BITS       (ADDR_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_req_type),
    .in_addr         (in_addr),
    .in_length       (in_length),
    .out_status      (out_status),
    .out_block_addr  (out_block_addr),
    .out_capacity    (out_capacity),
    .out_live_count  (out_live_count),
    .out_peak_count  (out_peak_count),
    .out_total_bytes (out_total_bytes)
  );

endmodule
